// ===== src/eskm_pkg.sv =====
`timescale 1ns / 1ps

package eskm_pkg;

    localparam int FUNC_W     = 2;
    localparam int KIDX_W     = 5;
    localparam int POS_W      = 3;
    localparam int KLEN_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int ENTRY_BYTES = 7;

    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PLAIN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPECIAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_META    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERASE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CHAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_META_ENABLE = 2'd1;

    localparam logic [BYTE_W-1:0] ESC_BYTE     = 8'd27;
    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
    localparam logic [BYTE_W-1:0] ERASE_RESET  = 8'd127;

    typedef struct packed {
        logic              we;
        logic [KIDX_W-1:0] index;
        logic [POS_W-1:0]  pos;
        logic [KLEN_W-1:0] length;
        logic [BYTE_W-1:0] data;
    } t_load_req;

    typedef logic [ENTRY_BYTES-1:0][BYTE_W-1:0] t_entry_chars;

endpackage

// ===== src/eskm_in_if.sv =====
`timescale 1ns / 1ps

interface eskm_in_if
    import eskm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KIDX_W-1:0] key_index;
    logic [POS_W-1:0]  char_pos;
    logic [KLEN_W-1:0] key_length;
    logic [BYTE_W-1:0] data_byte;

    modport source (
        output valid, func, key_index, char_pos, key_length, data_byte,
        input  ready
    );
    modport sink (
        input  valid, func, key_index, char_pos, key_length, data_byte,
        output ready
    );
endinterface

// ===== src/eskm_out_if.sv =====
`timescale 1ns / 1ps

interface eskm_out_if
    import eskm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic              last;

    modport source (
        output valid, kind, value, last,
        input  ready
    );
    modport sink (
        input  valid, kind, value, last,
        output ready
    );
endinterface

// ===== src/eskm_cfg_if.sv =====
`timescale 1ns / 1ps

interface eskm_cfg_if
    import eskm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== src/eskm_ram.sv =====
`timescale 1ns / 1ps

module eskm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/eskm_key_table.sv =====
`timescale 1ns / 1ps

module eskm_key_table
    import eskm_pkg::*;
#(
    parameter int NUM_ENTRIES = 32
) (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  t_load_req                                               i_load,
    input  logic [((NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1)-1:0] i_rd_addr,
    output t_entry_chars                                            o_rd_chars,
    output logic [KLEN_W-1:0]                                       o_rd_length
);

    localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic              w_in_range;
    logic [EW-1:0]     w_waddr;
    logic [KLEN_W-1:0] r_len [NUM_ENTRIES];
    logic [KLEN_W-1:0] r_rd_len;

    assign w_in_range = i_load.we && (32'(i_load.index) < NUM_ENTRIES);
    assign w_waddr    = EW'(i_load.index);

    for (genvar p = 0; p < ENTRY_BYTES; p++) begin : g_byte
        eskm_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (NUM_ENTRIES)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_in_range && (32'(i_load.pos) == p)),
            .i_waddr (w_waddr),
            .i_wdata (i_load.data),
            .i_raddr (i_rd_addr),
            .o_rdata (o_rd_chars[p])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                r_len[e] <= '0;
            end
        end else if (w_in_range) begin
            r_len[w_waddr] <= i_load.length;
        end
        r_rd_len <= r_len[i_rd_addr];
    end

    assign o_rd_length = r_rd_len;

endmodule

// ===== src/escape_sequence_key_matcher.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Payload
// i_in      in         valid/ready    func, key_index, char_pos, key_length, data_byte
// o_out     out        valid/ready    kind, value, last
// i_cfg     in         valid/ready    index, data (ready always high)
//
// A load, an ignored item or a tick with an empty buffer leaves the sequencer idle; a tick
// with bytes buffered flushes them as plain results. A newline or erase byte arriving first
// gives a single result. Any other received byte walks the key table one entry per cycle
// through the registered read port of the table RAMs, stopping early on a full match, and
// then delivers any results.
// Reset is synchronous and active low; it clears the entry lengths, buffer count and
// output valid and restores the configuration defaults. A stalled output holds the
// sequencer only when a new result is ready; the next item is accepted while the last
// result waits.

module escape_sequence_key_matcher
    import eskm_pkg::*;
#(
    parameter int NUM_ENTRIES = 32,
    parameter int MAX_SEQ     = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    eskm_in_if.sink       i_in,
    eskm_out_if.source    o_out,
    eskm_cfg_if.sink      i_cfg
);

    localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_SEQ + 1);
    localparam int BW = $clog2(MAX_SEQ);
    localparam logic [EW-1:0] LAST_ENTRY = EW'(NUM_ENTRIES - 1);
    localparam logic [CW-1:0] SEQ_FULL   = CW'(MAX_SEQ);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_EMIT  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [BYTE_W-1:0] r_buf [MAX_SEQ];
    logic [BYTE_W-1:0] n_buf [MAX_SEQ];
    logic [BYTE_W-1:0] r_erase, n_erase;
    logic              r_meta, n_meta;
    logic [EW-1:0]     r_entry, n_entry;
    logic              r_issue, n_issue;
    logic              r_cmp_valid, n_cmp_valid;
    logic [EW-1:0]     r_cmp_entry, n_cmp_entry;
    logic              r_matched, n_matched;
    logic [KIND_W-1:0] r_res_kind, n_res_kind;
    logic [BYTE_W-1:0] r_res_value, n_res_value;
    logic [BW-1:0]     r_fidx, n_fidx;
    logic              r_ov, n_ov;
    logic [KIND_W-1:0] r_okind, n_okind;
    logic [BYTE_W-1:0] r_oval, n_oval;
    logic              r_olast, n_olast;

    t_load_req         w_load;
    t_entry_chars      w_chars;
    logic [KLEN_W-1:0] w_length;
    logic [BYTE_W-1:0] w_pad [ENTRY_BYTES];
    logic              w_in_acc;
    logic              w_out_free;
    logic [CW-1:0]     w_eff;
    logic              w_eq;
    logic              w_pm;
    logic              w_full;
    logic              w_any;
    logic              w_flush_last;

    for (genvar p = 0; p < ENTRY_BYTES; p++) begin : g_pad
        if (p < MAX_SEQ) begin : g_buf
            assign w_pad[p] = r_buf[p];
        end else begin : g_zero
            assign w_pad[p] = '0;
        end
    end

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ov || o_out.ready;

    assign w_load.we     = w_in_acc && (i_in.func == FUNC_LOAD);
    assign w_load.index  = i_in.key_index;
    assign w_load.pos    = i_in.char_pos;
    assign w_load.length = i_in.key_length;
    assign w_load.data   = i_in.data_byte;

    eskm_key_table #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_rd_addr   (r_entry),
        .o_rd_chars  (w_chars),
        .o_rd_length (w_length)
    );

    always_comb begin
        w_eq = 1'b1;
        for (int p = 0; p < ENTRY_BYTES; p++) begin
            if ((32'(r_count) > p) && (w_chars[p] != w_pad[p])) begin
                w_eq = 1'b0;
            end
        end
        w_pm   = (32'(w_length) >= 32'(r_count)) && w_eq;
        w_full = w_pm && (32'(w_length) == 32'(r_count));
        w_any  = r_matched || w_pm;
    end

    assign w_eff        = (r_count >= SEQ_FULL) ? '0 : r_count;
    assign w_flush_last = (CW'(r_fidx) + CW'(1)) == r_count;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_buf       = r_buf;
        n_erase     = r_erase;
        n_meta      = r_meta;
        n_entry     = r_entry;
        n_issue     = r_issue;
        n_cmp_valid = r_cmp_valid;
        n_cmp_entry = r_cmp_entry;
        n_matched   = r_matched;
        n_res_kind  = r_res_kind;
        n_res_value = r_res_value;
        n_fidx      = r_fidx;
        n_ov        = r_ov && !o_out.ready;
        n_okind     = r_okind;
        n_oval      = r_oval;
        n_olast     = r_olast;

        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ERASE_CHAR:  n_erase = i_cfg.data[BYTE_W-1:0];
                CFG_META_ENABLE: n_meta  = i_cfg.data[0];
                default:         ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.func)
                        FUNC_BYTE: begin
                            if ((w_eff == '0) && (i_in.data_byte == NEWLINE_BYTE)) begin
                                n_count     = '0;
                                n_res_kind  = KIND_PLAIN;
                                n_res_value = i_in.data_byte;
                                n_state     = S_EMIT;
                            end else if ((w_eff == '0) && (i_in.data_byte == r_erase)) begin
                                n_count     = '0;
                                n_res_kind  = KIND_ERASE;
                                n_res_value = i_in.data_byte;
                                n_state     = S_EMIT;
                            end else begin
                                n_buf[w_eff[BW-1:0]] = i_in.data_byte;
                                n_count     = w_eff + CW'(1);
                                n_entry     = '0;
                                n_issue     = 1'b1;
                                n_cmp_valid = 1'b0;
                                n_matched   = 1'b0;
                                n_state     = S_SCAN;
                            end
                        end
                        FUNC_TICK: begin
                            if (r_count != '0) begin
                                n_fidx  = '0;
                                n_state = S_FLUSH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                n_cmp_valid = r_issue;
                n_cmp_entry = r_entry;
                if (r_issue) begin
                    if (r_entry == LAST_ENTRY) begin
                        n_issue = 1'b0;
                    end else begin
                        n_entry = r_entry + EW'(1);
                    end
                end
                if (r_cmp_valid) begin
                    n_matched = w_any;
                    if (w_full) begin
                        n_count     = '0;
                        n_res_kind  = KIND_SPECIAL;
                        n_res_value = BYTE_W'(r_cmp_entry);
                        n_issue     = 1'b0;
                        n_cmp_valid = 1'b0;
                        n_state     = S_EMIT;
                    end else if (r_cmp_entry == LAST_ENTRY) begin
                        n_cmp_valid = 1'b0;
                        if (r_meta && !w_any && (r_count == CW'(2))
                                && (r_buf[0] == ESC_BYTE)) begin
                            n_count     = '0;
                            n_res_kind  = KIND_META;
                            n_res_value = r_buf[1];
                            n_state     = S_EMIT;
                        end else if (!w_any || (r_count >= SEQ_FULL)) begin
                            n_fidx  = '0;
                            n_state = S_FLUSH;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_okind = r_res_kind;
                    n_oval  = r_res_value;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_okind = KIND_PLAIN;
                    n_oval  = r_buf[r_fidx];
                    n_olast = w_flush_last;
                    if (w_flush_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_fidx = r_fidx + BW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_erase     <= ERASE_RESET;
            r_meta      <= 1'b1;
            r_issue     <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_matched   <= 1'b0;
            r_entry     <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_erase     <= n_erase;
            r_meta      <= n_meta;
            r_issue     <= n_issue;
            r_cmp_valid <= n_cmp_valid;
            r_matched   <= n_matched;
            r_entry     <= n_entry;
            r_ov        <= n_ov;
        end
        r_buf       <= n_buf;
        r_cmp_entry <= n_cmp_entry;
        r_res_kind  <= n_res_kind;
        r_res_value <= n_res_value;
        r_fidx      <= n_fidx;
        r_okind     <= n_okind;
        r_oval      <= n_oval;
        r_olast     <= n_olast;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.kind  = r_okind;
    assign o_out.value = r_oval;
    assign o_out.last  = r_olast;

endmodule
